/* hw/rtl/grp_pkg.sv */
// Shared types, constants and helper functions for the greedy rectangle placer.
// Used by grp_ctrl, grp_datapath and greedy_rectangle_placer; no dependencies.
`timescale 1ns / 1ps

package grp_pkg;

   localparam int GRID_W = 64;
   localparam int GRID_H = 64;
   localparam int CW     = 7;                  // coordinate / extent width
   localparam int XIW    = $clog2(GRID_W);     // column index width
   localparam int YIW    = $clog2(GRID_H);     // row index width
   localparam int YCW    = $clog2(GRID_H + 1); // row counter width
   localparam int FREE_W = 13;
   localparam int FREE_MAX = 8191;

   localparam logic [7:0] REG_FLOOR_WIDTH  = 8'd0;
   localparam logic [7:0] REG_FLOOR_HEIGHT = 8'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ANCHOR,
      ST_COLY,
      ST_TRY,
      ST_CHECK,
      ST_MARK,
      ST_RESP
   } state_type;

   typedef enum logic [1:0] {
      SW_ANCHOR,
      SW_COLY,
      SW_CHECK,
      SW_MARK
   } sweep_type;

   typedef struct packed {
      logic       load;
      logic       start_coly;
      logic       start_check;
      logic       start_mark;
      logic       commit;
      logic       fail;
      logic [1:0] try_idx;
   } cmd_type;

   typedef struct packed {
      logic sweep_done;
      logic cand_ok;
      logic conflict;
   } status_type;

   // bits [n-1:0] set
   function automatic logic [GRID_W-1:0] low_mask(input logic [CW:0] n);
      logic [GRID_W-1:0] m;
      for (int i = 0; i < GRID_W; i++) begin
         m[i] = (9'(i) < {1'b0, n});
      end
      return m;
   endfunction

   function automatic logic [XIW-1:0] lowest_bit(input logic [GRID_W-1:0] v);
      logic [XIW-1:0] idx;
      idx = '0;
      for (int i = GRID_W - 1; i >= 0; i--) begin
         if (v[i]) idx = XIW'(i);
      end
      return idx;
   endfunction

endpackage

/* hw/rtl/grp_ctrl.sv */
// Sequencer for the placer: anchor scans, up to four fit checks, mark, response.
// Depends on grp_pkg; drives grp_datapath through cmd_type / status_type.
`timescale 1ns / 1ps

module grp_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output grp_pkg::cmd_type    cmd,
   input  grp_pkg::status_type status
);
   import grp_pkg::*;

   state_type  state_ff, state_in;
   logic [1:0] k_ff, k_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_ANCHOR;
         end
         ST_ANCHOR: begin
            if (status.sweep_done) state_in = ST_COLY;
         end
         ST_COLY: begin
            if (status.sweep_done) begin
               state_in = ST_TRY;
               k_in     = '0;
            end
         end
         ST_TRY: begin
            if (status.cand_ok) state_in = ST_CHECK;
            else if (k_ff == 2'd3) state_in = ST_RESP;
            else k_in = k_ff + 2'd1;
         end
         ST_CHECK: begin
            if (status.sweep_done) begin
               if (!status.conflict) state_in = ST_MARK;
               else if (k_ff == 2'd3) state_in = ST_RESP;
               else begin
                  state_in = ST_TRY;
                  k_in     = k_ff + 2'd1;
               end
            end
         end
         ST_MARK: begin
            if (status.sweep_done) state_in = ST_RESP;
         end
         ST_RESP: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd         = '0;
      cmd.try_idx = k_ff;
      req_tready  = (state_ff == ST_IDLE);
      rsp_tvalid  = (state_ff == ST_RESP);
      unique case (state_ff)
         ST_IDLE:   cmd.load = req_tvalid;
         ST_ANCHOR: cmd.start_coly = status.sweep_done;
         ST_COLY:   ;
         ST_TRY: begin
            cmd.start_check = status.cand_ok;
            cmd.fail        = !status.cand_ok && (k_ff == 2'd3);
         end
         ST_CHECK: begin
            cmd.start_mark = status.sweep_done && !status.conflict;
            cmd.fail       = status.sweep_done && status.conflict && (k_ff == 2'd3);
         end
         ST_MARK:   cmd.commit = status.sweep_done;
         ST_RESP:   ;
         default:   ;
      endcase
   end

endmodule

/* hw/rtl/grp_datapath.sv */
// Occupancy row memory, row sweep engine, anchors, fit check, mark and free count.
// Depends on grp_pkg; commanded by grp_ctrl.
`timescale 1ns / 1ps

module grp_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [15:0]           req_tdata,   // tile_width[6:0], tile_height[13:7]
   input  logic                  csr_fire,
   input  logic [7:0]            csr_index,
   input  logic [6:0]            csr_data,
   input  grp_pkg::cmd_type      cmd,
   output grp_pkg::status_type   status,
   output logic [31:0]           rsp_tdata    // placed, pos_x, pos_y, rotated, column_scan,
                                              // free_cells
);
   import grp_pkg::*;

   function automatic logic [CW-1:0] clip(input logic [CW-1:0] v, input int lim);
      return (v > CW'(lim)) ? CW'(lim) : v;
   endfunction

   function automatic logic [FREE_W-1:0] area_of(input logic [CW-1:0] w,
                                                input logic [CW-1:0] h);
      logic [2*CW-1:0] a;
      a = clip(w, GRID_W) * clip(h, GRID_H);
      return (a > (2*CW)'(FREE_MAX)) ? FREE_W'(FREE_MAX) : a[FREE_W-1:0];
   endfunction

   // configuration and counters
   logic [CW-1:0]     fw_ff, fh_ff, fw_in, fh_in;
   logic [FREE_W-1:0] free_ff, free_in;
   logic [CW-1:0]     uw, uh;
   logic [CW-1:0]     tw_ff, th_ff;

   // memory
   logic [GRID_W-1:0] mem [GRID_H];
   logic [GRID_H-1:0] row_vld_ff;
   logic [GRID_W-1:0] rdata_ff;
   logic              rvld_ff;
   logic              mem_we;
   logic [GRID_W-1:0] mem_wdata;

   // sweep engine
   logic              busy_ff;
   sweep_type         mode_ff;
   logic [YCW-1:0]    issue_ff, hi_ff;
   logic              ret_vld_ff;
   logic [YIW-1:0]    ret_row_ff;
   logic              rd_en;
   logic [YIW-1:0]    rd_addr;
   logic [GRID_W-1:0] row_data, free_bits;

   // anchors
   logic              rfound_ff, cfound_ff;
   logic [CW-1:0]     rax_ff, ray_ff, cay_ff;
   logic [GRID_W-1:0] colfree_ff;
   logic [CW-1:0]     cax;
   logic              ok0, ok1;

   // candidate
   logic              s_sel, r_sel, c_ok;
   logic [CW-1:0]     c_w, c_h, c_x, c_y;
   logic [CW-1:0]     cx_ff, cy_ff, cw_ff, ch_ff;
   logic              crot_ff, ccol_ff, conflict_ff;
   logic [GRID_W-1:0] pmask_ff;
   logic [2*CW-1:0]   tile_area;

   // result
   logic              res_placed_ff, res_rot_ff, res_col_ff;
   logic [CW-1:0]     res_x_ff, res_y_ff;
   logic [FREE_W-1:0] res_free_ff;

   assign uw = clip(fw_ff, GRID_W);
   assign uh = clip(fh_ff, GRID_H);

   assign rd_en   = busy_ff && (issue_ff < hi_ff);
   assign rd_addr = issue_ff[YIW-1:0];
   assign row_data  = rvld_ff ? rdata_ff : '0;
   assign free_bits = ~row_data & low_mask({1'b0, uw});
   assign mem_we    = ret_vld_ff && (mode_ff == SW_MARK);
   assign mem_wdata = row_data | pmask_ff;

   assign cax = CW'(lowest_bit(colfree_ff));
   assign ok0 = (free_ff != '0) && rfound_ff;
   assign ok1 = (free_ff != '0) && (colfree_ff != '0);

   assign s_sel = cmd.try_idx[1];
   assign r_sel = cmd.try_idx[0];
   assign c_w   = r_sel ? th_ff : tw_ff;
   assign c_h   = r_sel ? tw_ff : th_ff;
   assign c_x   = s_sel ? cax : rax_ff;
   assign c_y   = s_sel ? cay_ff : ray_ff;
   assign c_ok  = (s_sel ? ok1 : ok0) && (c_w != '0) && (c_h != '0)
                  && (({1'b0, c_x} + {1'b0, c_w}) <= {1'b0, uw})
                  && (({1'b0, c_y} + {1'b0, c_h}) <= {1'b0, uh});
   assign tile_area = cw_ff * ch_ff;

   assign status.sweep_done = busy_ff && !rd_en && !ret_vld_ff;
   assign status.cand_ok    = c_ok;
   assign status.conflict   = conflict_ff;

   always_comb begin
      fw_in   = fw_ff;
      fh_in   = fh_ff;
      free_in = free_ff;
      if (csr_fire && (csr_index == REG_FLOOR_WIDTH || csr_index == REG_FLOOR_HEIGHT)) begin
         if (csr_index == REG_FLOOR_WIDTH) fw_in = csr_data;
         else fh_in = csr_data;
         free_in = area_of(fw_in, fh_in);
      end else if (cmd.commit) begin
         free_in = ({1'b0, free_ff} > (FREE_W+1)'(tile_area))
                   ? FREE_W'({1'b0, free_ff} - (FREE_W+1)'(tile_area)) : '0;
      end
   end

   // memory: registered read, write on mark returns
   always_ff @(posedge clock) begin
      if (mem_we) mem[ret_row_ff] <= mem_wdata;
      rdata_ff <= mem[rd_addr];
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= CW'(64);
         fh_ff      <= CW'(64);
         free_ff    <= area_of(CW'(64), CW'(64));
         row_vld_ff <= '0;
         busy_ff    <= 1'b0;
         ret_vld_ff <= 1'b0;
      end else begin
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         free_ff    <= free_in;
         ret_vld_ff <= rd_en;
         if (mem_we) row_vld_ff[ret_row_ff] <= 1'b1;
         if (cmd.load || cmd.start_coly || cmd.start_check || cmd.start_mark)
            busy_ff <= 1'b1;
         else if (status.sweep_done)
            busy_ff <= 1'b0;
      end
   end

   // sweep, anchor and candidate payload
   always_ff @(posedge clock) begin
      rvld_ff    <= row_vld_ff[rd_addr];
      ret_row_ff <= rd_addr;
      if (rd_en) issue_ff <= issue_ff + YCW'(1);

      if (cmd.load) begin
         tw_ff      <= req_tdata[6:0];
         th_ff      <= req_tdata[13:7];
         mode_ff    <= SW_ANCHOR;
         issue_ff   <= '0;
         hi_ff      <= YCW'(uh);
         rfound_ff  <= 1'b0;
         colfree_ff <= '0;
      end
      if (cmd.start_coly) begin
         mode_ff   <= SW_COLY;
         issue_ff  <= '0;
         hi_ff     <= YCW'(uh);
         cfound_ff <= 1'b0;
      end
      if (cmd.start_check) begin
         mode_ff     <= SW_CHECK;
         issue_ff    <= YCW'(c_y);
         hi_ff       <= YCW'(c_y + c_h);
         conflict_ff <= 1'b0;
         cx_ff       <= c_x;
         cy_ff       <= c_y;
         cw_ff       <= c_w;
         ch_ff       <= c_h;
         crot_ff     <= r_sel;
         ccol_ff     <= s_sel;
         pmask_ff    <= low_mask({1'b0, c_w}) << c_x;
      end
      if (cmd.start_mark) begin
         mode_ff  <= SW_MARK;
         issue_ff <= YCW'(cy_ff);
         hi_ff    <= YCW'(cy_ff + ch_ff);
      end

      if (ret_vld_ff) begin
         unique case (mode_ff)
            SW_ANCHOR: begin
               colfree_ff <= colfree_ff | free_bits;
               if (!rfound_ff && free_bits != '0) begin
                  rfound_ff <= 1'b1;
                  rax_ff    <= CW'(lowest_bit(free_bits));
                  ray_ff    <= CW'(ret_row_ff);
               end
            end
            SW_COLY: begin
               if (!cfound_ff && free_bits[cax[XIW-1:0]]) begin
                  cfound_ff <= 1'b1;
                  cay_ff    <= CW'(ret_row_ff);
               end
            end
            SW_CHECK: begin
               if ((row_data & pmask_ff) != '0) conflict_ff <= 1'b1;
            end
            SW_MARK: ;
            default: ;
         endcase
      end

      if (cmd.commit) begin
         res_placed_ff <= 1'b1;
         res_x_ff      <= cx_ff;
         res_y_ff      <= cy_ff;
         res_rot_ff    <= crot_ff;
         res_col_ff    <= ccol_ff;
         res_free_ff   <= free_in;
      end else if (cmd.fail) begin
         res_placed_ff <= 1'b0;
         res_x_ff      <= ok0 ? rax_ff : uw;
         res_y_ff      <= ok0 ? ray_ff : uh;
         res_rot_ff    <= 1'b0;
         res_col_ff    <= 1'b0;
         res_free_ff   <= free_ff;
      end
   end

   assign rsp_tdata = {2'b00, res_free_ff, res_col_ff, res_rot_ff,
                       res_y_ff, res_x_ff, res_placed_ff};

   a_free_bounded: assert property (@(posedge clock) disable iff (reset)
      free_ff <= FREE_W'(FREE_MAX))
      else $error("free count out of range");
   a_write_in_sweep: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> busy_ff)
      else $error("row write outside a mark sweep");
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !cmd.load && !cmd.start_coly && !cmd.start_check && !cmd.start_mark)
      |=> (!busy_ff || issue_ff <= hi_ff || $past(cmd.load || cmd.start_coly)))
      else $error("sweep ran past its last row");
   a_mark_after_fit: assert property (@(posedge clock) disable iff (reset)
      cmd.start_mark |-> !conflict_ff)
      else $error("mark started on a conflicting placement");

endmodule

/* hw/rtl/greedy_rectangle_placer.sv */
// Greedy first-fit rectangle placer on a one-bit-per-cell floor map.
// Usage:
//   req_*  : one rectangle per transaction, tdata = tile_width[6:0], tile_height[13:7].
//   rsp_*  : one result per request, tdata = placed[0], pos_x[7:1], pos_y[14:8],
//            rotated[15], column_scan[16], free_cells[29:17].
//   csr_*  : register writes, index 0 = floor_width, 1 = floor_height; each write
//            reloads the free count with the usable floor area (map is kept).
// Sequence: rows are swept one per cycle through the row memory read port.
//   accept, anchor sweep over uh rows, column-anchor sweep over uh rows, then per
//   placement tried a bounds test and, if it passes, a fit check over its h rows;
//   on the first fit a mark over its h rows, then the response.
// Throughput: one request at a time; req_tready is high only while idle.
// Reset: synchronous, active high; all cells free (row valid bits cleared at once),
//   floor 64 x 64, free count 4096. No clearing pass.
// Stall: the result is held on rsp_tdata with rsp_tvalid high until rsp_tready;
//   no new request is taken meanwhile.
// Depends on grp_pkg, grp_ctrl, grp_datapath.
`timescale 1ns / 1ps

module greedy_rectangle_placer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // tile_width[6:0], tile_height[13:7]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // placed, pos_x, pos_y, rotated, column_scan, free_cells
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_index,
   input  logic [6:0]  csr_data
);
   import grp_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   grp_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   grp_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .csr_fire  (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for greedy_rectangle_placer: directed and random tile requests
// with floor-size writes, checked against an in-bench occupancy-map predictor.
// Depends on grp_pkg and the placer RTL.
`timescale 1ns / 1ps

module testbench;
   import grp_pkg::*;

   localparam logic [7:0] REG_UNUSED = 8'd5;
   localparam int TIMEOUT_CYCLES = 3000000;
   localparam int DRAIN_CYCLES = 500;

   // lowest field last, matching the rsp_tdata packing
   typedef struct packed {
      logic [FREE_W-1:0] free_cells;
      logic              column_scan;
      logic              rotated;
      logic [6:0]        pos_y;
      logic [6:0]        pos_x;
      logic              placed;
   } placement_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = '0;
   logic [6:0]  csr_data = '0;

   // predictor state
   logic [GRID_W-1:0] floor_map [GRID_H];
   int                free_left;
   int                floor_w_reg;
   int                floor_h_reg;

   placement_t pending_results [$];
   int         mismatches = 0;
   int         cycle_count = 0;
   int         send_gap_pct = 0;
   int         stall_pct = 0;

   greedy_rectangle_placer dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic int usable_w();
      return floor_w_reg < GRID_W ? floor_w_reg : GRID_W;
   endfunction

   function automatic int usable_h();
      return floor_h_reg < GRID_H ? floor_h_reg : GRID_H;
   endfunction

   function automatic void reload_free();
      int a;
      a = usable_w() * usable_h();
      free_left = a > FREE_MAX ? FREE_MAX : a;
   endfunction

   function automatic bit first_free(bit by_column, output int ax, output int ay);
      ax = usable_w();
      ay = usable_h();
      if (free_left == 0) return 0;
      if (!by_column) begin
         for (int y = 0; y < usable_h(); y++)
            for (int x = 0; x < usable_w(); x++)
               if (!floor_map[y][x]) begin
                  ax = x; ay = y; return 1;
               end
      end else begin
         for (int x = 0; x < usable_w(); x++)
            for (int y = 0; y < usable_h(); y++)
               if (!floor_map[y][x]) begin
                  ax = x; ay = y; return 1;
               end
      end
      return 0;
   endfunction

   function automatic bit area_free(int px, int py, int w, int h);
      if (w == 0 || h == 0) return 0;
      if (px + w > usable_w() || py + h > usable_h()) return 0;
      for (int y = py; y < py + h; y++)
         for (int x = px; x < px + w; x++)
            if (floor_map[y][x]) return 0;
      return 1;
   endfunction

   function automatic placement_t place_tile(int tw, int th);
      placement_t r;
      int ax [2];
      int ay [2];
      bit found [2];
      int s, w, h;
      found[0] = first_free(1'b0, ax[0], ay[0]);
      found[1] = first_free(1'b1, ax[1], ay[1]);
      r = '0;
      r.pos_x = 7'(ax[0]);
      r.pos_y = 7'(ay[0]);
      for (int k = 0; k < 4 && !r.placed; k++) begin
         s = k >> 1;
         w = k[0] ? th : tw;
         h = k[0] ? tw : th;
         if (found[s] && area_free(ax[s], ay[s], w, h)) begin
            for (int y = ay[s]; y < ay[s] + h; y++)
               for (int x = ax[s]; x < ax[s] + w; x++)
                  floor_map[y][x] = 1'b1;
            free_left = free_left > w * h ? free_left - w * h : 0;
            r.placed = 1'b1;
            r.pos_x = 7'(ax[s]);
            r.pos_y = 7'(ay[s]);
            r.rotated = k[0];
            r.column_scan = s[0];
         end
      end
      r.free_cells = FREE_W'(free_left);
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > TIMEOUT_CYCLES) begin
         $display("testbench NOT OK");
         $finish;
      end
   end

   // result checker
   always @(posedge clock) begin
      placement_t got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = placement_t'(rsp_tdata[29:0]);
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
         end else begin
            want = pending_results.pop_front();
            if (got.placed !== want.placed || got.pos_x !== want.pos_x ||
                got.pos_y !== want.pos_y || got.rotated !== want.rotated ||
                got.column_scan !== want.column_scan ||
                got.free_cells !== want.free_cells) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("placement mismatch: expected %p actual %p", want, got);
            end
         end
      end
   end

   task automatic send_tile(int tw, int th);
      while ($urandom_range(99) < send_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {2'b00, 7'(th), 7'(tw)};
      do @(posedge clock); while (!req_tready);
      pending_results.insert(pending_results.size(), place_tile(tw & 7'h7f, th & 7'h7f));
   endtask

   task automatic wait_results_drained();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(logic [7:0] idx, int value);
      wait_results_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= 7'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
      if (idx == REG_FLOOR_WIDTH) begin
         floor_w_reg = value & 7'h7f;
         reload_free();
      end else if (idx == REG_FLOOR_HEIGHT) begin
         floor_h_reg = value & 7'h7f;
         reload_free();
      end
   endtask

   task automatic set_floor(int w, int h);
      write_reg(REG_FLOOR_WIDTH, w);
      write_reg(REG_FLOOR_HEIGHT, h);
   endtask

   function automatic int random_extent();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(6, 1);
      if (r < 95) return $urandom_range(20, 1);
      if (r < 97) return 0;
      return $urandom_range(127);
   endfunction

   // small floor: zero extents, oversize, rotation, column anchor, full floor,
   // zero floor, floor beyond the grid, unused register index
   task automatic test_directed();
      set_floor(4, 3);
      send_tile(0, 2);
      send_tile(2, 0);
      send_tile(127, 127);
      send_tile(3, 1);
      send_tile(2, 2);   // only fits at the column-major anchor
      send_tile(1, 2);
      send_tile(3, 1);   // no placement fits
      send_tile(1, 3);
      for (int i = 0; i < 6; i++) send_tile(1, 1);
      send_tile(1, 1);   // floor full
      write_reg(REG_UNUSED, 7'h7f);
      send_tile(1, 1);
      set_floor(0, 3);
      send_tile(1, 1);
      set_floor(4, 0);
      send_tile(1, 1);
      set_floor(127, 127);
      send_tile(64, 64);
      send_tile(60, 1);
      send_tile(1, 64);
      send_tile(64, 1);
      wait_results_drained();
   endtask

   task automatic test_random_phase(int gap, int stall, int reach);
      int floors [5][2];
      send_gap_pct = gap;
      stall_pct = stall;
      floors = '{'{reach / 2, reach / 2}, '{reach, reach / 3}, '{reach / 3, reach},
                 '{reach, reach}, '{$urandom_range(127), $urandom_range(127)}};
      for (int c = 0; c < 5; c++) begin
         set_floor(floors[c][0], floors[c][1]);
         for (int i = 0; i < 70; i++) send_tile(random_extent(), random_extent());
      end
      wait_results_drained();
   endtask

   initial begin
      for (int y = 0; y < GRID_H; y++) floor_map[y] = '0;
      floor_w_reg = 64;
      floor_h_reg = 64;
      reload_free();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(15, 57, 24);
      test_random_phase(57, 15, 44);
      test_random_phase(0, 0, 64);
      set_floor(64, 64);
      for (int i = 0; i < 20; i++) send_tile(random_extent(), random_extent());
      wait_results_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

/* greedy_rectangle_placer.f */
hw/rtl/grp_pkg.sv
hw/rtl/grp_ctrl.sv
hw/rtl/grp_datapath.sv
hw/rtl/greedy_rectangle_placer.sv
tb/testbench.sv
